@@ hw/rtl/hmtd_pkg.sv @@
// Shared types, constants and the divide-by-65535 helper for the
// humidity/temperature frame decoder. No dependencies.
`timescale 1ns / 1ps

package hmtd_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_CRC_POLY   = 2'd0,
      CSR_CRC_INIT   = 2'd1,
      CSR_TEMP_OFS   = 2'd2,
      CSR_HUMI_OFS   = 2'd3
   } csr_index_type;

   localparam logic [7:0]         CRC_POLY_RESET = 8'h31;
   localparam logic [7:0]         CRC_INIT_RESET = 8'hFF;
   localparam logic signed [10:0] TEMP_OFS_RESET = -11'sd30;
   localparam logic signed [4:0]  HUMI_OFS_RESET = 5'sd1;

   // scale factors: raw * scale / 65535
   localparam logic [30:0] C_SCALE = 31'd17500;
   localparam logic [30:0] F_SCALE = 31'd31500;
   localparam logic [22:0] H_SCALE = 23'd100;
   // half of 65535, rounded down: rounds humidity half up
   localparam logic [22:0] H_BIAS  = 23'd32767;
   localparam logic [16:0] DIV_MOD = 17'd65535;

   localparam logic signed [16:0] C_BASE = 17'sd4500;
   localparam logic signed [16:0] F_BASE = 17'sd4900;

   typedef struct packed {
      logic [7:0]         crc_poly;
      logic [7:0]         crc_init;
      logic signed [10:0] temp_ofs;
      logic signed [4:0]  humi_ofs;
   } csr_type;

   // one decoded frame, front to back
   typedef struct packed {
      logic [15:0] temp_raw;
      logic [15:0] humi_raw;
      logic        temp_crc_ok;
      logic        humi_crc_ok;
   } frame_type;

   typedef struct packed {
      logic signed [14:0] temp_centi_c;
      logic signed [15:0] temp_centi_f;
      logic signed [7:0]  humidity_pct;
      logic               temp_crc_ok;
      logic               humi_crc_ok;
      logic               reading_valid;
   } rsp_type;

   typedef struct packed {
      logic [14:0] quo;
      logic        rem_nz;
   } div_type;

   // x / 65535 for x < 32768*65535: x = a*65535 + (a + b), and a + b < 2*65535
   function automatic div_type div65535(input logic [30:0] x);
      logic [16:0] s;
      logic        ge;
      div_type     d;
      s        = {2'b00, x[30:16]} + {1'b0, x[15:0]};
      ge       = (s >= DIV_MOD);
      d.quo    = x[30:16] + {14'd0, ge};
      d.rem_nz = ge ? (s != DIV_MOD) : (s != 17'd0);
      return d;
   endfunction

endpackage

@@ hw/rtl/hmtd_fifo.sv @@
// Small register queue with count, used between front and back and on the
// result side. Depends on nothing.
`timescale 1ns / 1ps

module hmtd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ hw/rtl/hmtd_front.sv @@
// Byte sequencer: tracks frame position, runs the CRC-8 and assembles the
// raw words. Uses hmtd_pkg.
`timescale 1ns / 1ps

module hmtd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_accept,
   input  logic [7:0]         rx_byte,
   input  logic               frame_start,
   input  hmtd_pkg::csr_type  csr,
   output logic               frame_push,
   output hmtd_pkg::frame_type frame
);
   import hmtd_pkg::*;

   typedef enum logic [5:0] {
      POS_T_HI = 6'b000001,
      POS_T_LO = 6'b000010,
      POS_T_CRC = 6'b000100,
      POS_H_HI = 6'b001000,
      POS_H_LO = 6'b010000,
      POS_H_CRC = 6'b100000
   } pos_type;

   pos_type     pos_ff, pos_in, cur_pos;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_raw_ff, temp_raw_in;
   logic [15:0] humi_raw_ff, humi_raw_in;
   logic        temp_ok_ff, temp_ok_in;

   function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] data,
                                       input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      humi_raw_in = humi_raw_ff;
      temp_ok_in  = temp_ok_ff;
      frame_push  = 1'b0;
      cur_pos     = frame_start ? POS_T_HI : pos_ff;
      if (byte_accept) begin
         unique case (cur_pos)
            POS_T_HI: begin
               crc_in            = crc8(csr.crc_init, rx_byte, csr.crc_poly);
               temp_raw_in[15:8] = rx_byte;
               pos_in            = POS_T_LO;
            end
            POS_T_LO: begin
               crc_in           = crc8(crc_ff, rx_byte, csr.crc_poly);
               temp_raw_in[7:0] = rx_byte;
               pos_in           = POS_T_CRC;
            end
            POS_T_CRC: begin
               temp_ok_in = (crc_ff == rx_byte);
               pos_in     = POS_H_HI;
            end
            POS_H_HI: begin
               crc_in            = crc8(csr.crc_init, rx_byte, csr.crc_poly);
               humi_raw_in[15:8] = rx_byte;
               pos_in            = POS_H_LO;
            end
            POS_H_LO: begin
               crc_in           = crc8(crc_ff, rx_byte, csr.crc_poly);
               humi_raw_in[7:0] = rx_byte;
               pos_in           = POS_H_CRC;
            end
            POS_H_CRC: begin
               frame_push = 1'b1;
               pos_in     = POS_T_HI;
            end
            default: begin
               // unreachable codes restart as a first byte
               crc_in            = crc8(csr.crc_init, rx_byte, csr.crc_poly);
               temp_raw_in[15:8] = rx_byte;
               pos_in            = POS_T_LO;
            end
         endcase
      end
   end

   assign frame.temp_raw    = temp_raw_ff;
   assign frame.humi_raw    = humi_raw_ff;
   assign frame.temp_crc_ok = temp_ok_ff;
   assign frame.humi_crc_ok = (crc_ff == rx_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_T_HI;
         crc_ff <= CRC_INIT_RESET;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_raw_ff <= temp_raw_in;
      humi_raw_ff <= humi_raw_in;
      temp_ok_ff  <= temp_ok_in;
   end

endmodule

@@ hw/rtl/hmtd_back.sv @@
// Conversion pipeline: scale multiply, divide by 65535, add offsets, truncate
// temperatures toward zero and round humidity half up. Uses hmtd_pkg.
`timescale 1ns / 1ps

module hmtd_back (
   input  logic                clock,
   input  logic                reset,
   input  hmtd_pkg::csr_type   csr,
   input  logic                frame_avail,
   input  hmtd_pkg::frame_type frame,
   output logic                frame_pop,
   input  logic                rsp_full,
   output logic                rsp_push,
   output hmtd_pkg::rsp_type   rsp
);
   import hmtd_pkg::*;

   // stage 1: products
   logic        s1_valid_ff;
   logic [30:0] s1_prod_c_ff, s1_prod_f_ff;
   logic [22:0] s1_prod_h_ff;
   logic        s1_tok_ff, s1_hok_ff, s1_rdv_ff;
   // stage 2: quotients
   logic        s2_valid_ff;
   div_type     s2_div_c_ff, s2_div_f_ff;
   logic [6:0]  s2_quo_h_ff;
   logic        s2_tok_ff, s2_hok_ff, s2_rdv_ff;

   logic        advance;
   div_type     div_c, div_f, div_h;
   logic signed [16:0] sum_c, sum_f, res_c, res_f;
   logic signed [7:0]  hum;

   // hold the whole pipe while the last stage cannot drain
   assign advance   = !(s2_valid_ff && rsp_full);
   assign frame_pop = advance && frame_avail;
   assign rsp_push  = s2_valid_ff && !rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= frame_avail;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign div_c = div65535(s1_prod_c_ff);
   assign div_f = div65535(s1_prod_f_ff);
   assign div_h = div65535({8'd0, s1_prod_h_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_c_ff <= {15'd0, frame.temp_raw} * C_SCALE;
         s1_prod_f_ff <= {15'd0, frame.temp_raw} * F_SCALE;
         s1_prod_h_ff <= {7'd0, frame.humi_raw} * H_SCALE + H_BIAS;
         s1_tok_ff    <= frame.temp_crc_ok;
         s1_hok_ff    <= frame.humi_crc_ok;
         s1_rdv_ff    <= (frame.temp_raw != 16'h0000) && (frame.temp_raw != 16'hFFFF);
         s2_div_c_ff  <= div_c;
         s2_div_f_ff  <= div_f;
         s2_quo_h_ff  <= div_h.quo[6:0];
         s2_tok_ff    <= s1_tok_ff;
         s2_hok_ff    <= s1_hok_ff;
         s2_rdv_ff    <= s1_rdv_ff;
      end
   end

   // a negative sum with a fraction left over rounds up toward zero
   always_comb begin
      sum_c = $signed({2'b00, s2_div_c_ff.quo}) + 17'(csr.temp_ofs) - C_BASE;
      sum_f = $signed({2'b00, s2_div_f_ff.quo}) + 17'(csr.temp_ofs) - F_BASE;
      res_c = (sum_c[16] && s2_div_c_ff.rem_nz) ? sum_c + 17'sd1 : sum_c;
      res_f = (sum_f[16] && s2_div_f_ff.rem_nz) ? sum_f + 17'sd1 : sum_f;
      hum   = $signed({1'b0, s2_quo_h_ff}) + 8'(csr.humi_ofs);
   end

   assign rsp.temp_centi_c  = s2_rdv_ff ? res_c[14:0] : '0;
   assign rsp.temp_centi_f  = s2_rdv_ff ? res_f[15:0] : '0;
   assign rsp.humidity_pct  = s2_rdv_ff ? hum : '0;
   assign rsp.temp_crc_ok   = s2_tok_ff;
   assign rsp.humi_crc_ok   = s2_hok_ff;
   assign rsp.reading_valid = s2_rdv_ff;

endmodule

@@ hw/rtl/humidity_temp_frame_decoder.sv @@
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------------
// request   | push / full            | req_rx_byte, req_frame_start
// response  | empty / pop            | rsp_temp_centi_c/_f, rsp_humidity_pct, flags
// csr write | valid / ready          | csr_index, csr_wdata (ready always high)
//
// One byte is taken every cycle while full is low; the sixth byte of a frame
// queues the frame, whose response then passes a two-stage multiply/divide pipe.
// Reset is synchronous and needs no clearing pass.
// A frame queue between sequencer and pipe lets the byte side keep going
// while responses are held; full rises only when that queue is full.
// Top level: CSR register file, byte sequencer, frame queue, conversion pipe
// and response queue. Uses hmtd_pkg, hmtd_front, hmtd_fifo, hmtd_back.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder #(
   parameter int FRAME_DEPTH = 4,
   parameter int RSP_DEPTH   = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               empty,
   input  logic               pop,
   output logic signed [14:0] rsp_temp_centi_c,
   output logic signed [15:0] rsp_temp_centi_f,
   output logic signed [7:0]  rsp_humidity_pct,
   output logic               rsp_temp_crc_ok,
   output logic               rsp_humi_crc_ok,
   output logic               rsp_reading_valid,
   input  logic               valid,
   output logic               ready,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_wdata
);
   import hmtd_pkg::*;

   csr_type   csr_ff, csr_in;
   frame_type front_frame, back_frame;
   rsp_type   back_rsp, head_rsp;
   logic      byte_accept, frame_push, frame_empty, frame_full, frame_pop;
   logic      rsp_push, rsp_full;

   assign ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CRC_POLY: csr_in.crc_poly = csr_wdata[7:0];
            CSR_CRC_INIT: csr_in.crc_init = csr_wdata[7:0];
            CSR_TEMP_OFS: csr_in.temp_ofs = $signed(csr_wdata);
            CSR_HUMI_OFS: csr_in.humi_ofs = $signed(csr_wdata[4:0]);
            default:      csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.crc_poly <= CRC_POLY_RESET;
         csr_ff.crc_init <= CRC_INIT_RESET;
         csr_ff.temp_ofs <= TEMP_OFS_RESET;
         csr_ff.humi_ofs <= HUMI_OFS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign byte_accept = push && !full;
   assign full        = frame_full;

   hmtd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .csr         (csr_ff),
      .frame_push  (frame_push),
      .frame       (front_frame)
   );

   hmtd_fifo #(
      .WIDTH ($bits(frame_type)),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (frame_push),
      .wr_data (front_frame),
      .rd_en   (frame_pop),
      .rd_data (back_frame),
      .empty   (frame_empty),
      .full    (frame_full)
   );

   hmtd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .frame_avail (!frame_empty),
      .frame       (back_frame),
      .frame_pop   (frame_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp         (back_rsp)
   );

   hmtd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (back_rsp),
      .rd_en   (pop),
      .rd_data (head_rsp),
      .empty   (empty),
      .full    (rsp_full)
   );

   assign rsp_temp_centi_c  = head_rsp.temp_centi_c;
   assign rsp_temp_centi_f  = head_rsp.temp_centi_f;
   assign rsp_humidity_pct  = head_rsp.humidity_pct;
   assign rsp_temp_crc_ok   = head_rsp.temp_crc_ok;
   assign rsp_humi_crc_ok   = head_rsp.humi_crc_ok;
   assign rsp_reading_valid = head_rsp.reading_valid;

endmodule

@@ hw/rtl/hmtd_checker.sv @@
// Port-level checks for the frame decoder, bound to the top level.
// Depends on humidity_temp_frame_decoder's port list only.
`timescale 1ns / 1ps

module hmtd_checker (
   input logic               clock,
   input logic               reset,
   input logic               full,
   input logic               empty,
   input logic               pop,
   input logic signed [14:0] rsp_temp_centi_c,
   input logic signed [15:0] rsp_temp_centi_f,
   input logic signed [7:0]  rsp_humidity_pct,
   input logic               rsp_reading_valid
);

   // reset drains both queues
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("response queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("request side full after reset");

   // an unusable reading carries zero values
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_reading_valid) |->
         (rsp_temp_centi_c == 15'sd0 && rsp_temp_centi_f == 16'sd0 &&
          rsp_humidity_pct == 8'sd0))
      else $error("invalid reading with nonzero values");

   // hold the head beat until it is popped
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_temp_centi_c) &&
                            $stable(rsp_temp_centi_f) && $stable(rsp_humidity_pct)))
      else $error("response beat changed before pop");

endmodule

bind humidity_temp_frame_decoder hmtd_checker u_hmtd_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_temp_centi_c  (rsp_temp_centi_c),
   .rsp_temp_centi_f  (rsp_temp_centi_f),
   .rsp_humidity_pct  (rsp_humidity_pct),
   .rsp_reading_valid (rsp_reading_valid)
);

@@ verif/testbench.sv @@
// Self-checking bench for humidity_temp_frame_decoder: drives sensor bytes
// through the push/full side, predicts each decoded reading and checks it.
// Depends on hmtd_pkg and the humidity_temp_frame_decoder top level.
`timescale 1ns / 1ps

module testbench;
   import hmtd_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 250;
   localparam int NUM_PHASES    = 5;
   localparam int REPORT_LIMIT  = 10;

   // invalid frames report zero values, only the CRC flags carry information
   localparam rsp_type NO_READING_HUMI_BAD = {15'd0, 16'd0, 8'd0, 1'b1, 1'b0, 1'b0};
   localparam rsp_type NO_READING_CRCS_OK  = {15'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b0};

   typedef struct {
      logic [7:0] rx_byte;
      logic       frame_start;
      bit         typed;
      rsp_type    reading;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               push;
   logic               full;
   logic [7:0]         req_rx_byte;
   logic               req_frame_start;
   logic               empty;
   logic               pop;
   logic signed [14:0] rsp_temp_centi_c;
   logic signed [15:0] rsp_temp_centi_f;
   logic signed [7:0]  rsp_humidity_pct;
   logic               rsp_temp_crc_ok;
   logic               rsp_humi_crc_ok;
   logic               rsp_reading_valid;
   logic               valid;
   logic               ready;
   logic [1:0]         csr_index;
   logic [10:0]        csr_wdata;

   // decoder shadow state
   csr_type     cfg;
   logic [2:0]  byte_pos;
   logic [7:0]  crc_acc;
   logic [15:0] temp_word;
   logic [7:0]  humi_hi;
   logic [7:0]  humi_lo;
   logic        temp_crc_match;

   rsp_type     pending_readings [$];
   int          error_count = 0;
   int          bytes_sent  = 0;
   int          idle_cycles = 0;
   bit          tx_burst    = 1'b0;

   // corner frames at reset settings: zero word, all-ones word, resync, bad CRC
   stim_row_type directed_rows [26] = '{
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h81, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, NO_READING_HUMI_BAD},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hAC, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hAC, 1'b0, 1'b1, NO_READING_CRCS_OK},
      '{8'h12, 1'b0, 1'b0, '0}, '{8'h34, 1'b0, 1'b0, '0},
      '{8'hBE, 1'b1, 1'b0, '0}, '{8'hEF, 1'b0, 1'b0, '0}, '{8'h92, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h81, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hAC, 1'b0, 1'b0, '0}
   };

   humidity_temp_frame_decoder dut (
      .clock, .reset, .push, .full, .req_rx_byte, .req_frame_start,
      .empty, .pop, .rsp_temp_centi_c, .rsp_temp_centi_f, .rsp_humidity_pct,
      .rsp_temp_crc_ok, .rsp_humi_crc_ok, .rsp_reading_valid,
      .valid, .ready, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++)
         c = c[7] ? ((c << 1) ^ cfg.crc_poly) : (c << 1);
      return c;
   endfunction

   // advance the shadow decoder by one byte; returns 1 when a reading is due
   function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                      output rsp_type r);
      logic [2:0] pos;
      longint     raw;
      longint     hraw;
      longint     tofs;
      longint     hofs;
      bit         good;
      r   = '0;
      pos = st ? 3'd0 : byte_pos;
      case (pos)
         3'd1: begin
            crc_acc        = crc8_step(crc_acc, b);
            temp_word[7:0] = b;
            byte_pos       = 3'd2;
            return 1'b0;
         end
         3'd2: begin
            temp_crc_match = (crc_acc == b);
            byte_pos       = 3'd3;
            return 1'b0;
         end
         3'd3: begin
            crc_acc  = crc8_step(cfg.crc_init, b);
            humi_hi  = b;
            byte_pos = 3'd4;
            return 1'b0;
         end
         3'd4: begin
            crc_acc  = crc8_step(crc_acc, b);
            humi_lo  = b;
            byte_pos = 3'd5;
            return 1'b0;
         end
         3'd5: begin
            good            = (temp_word != 16'h0000) && (temp_word != 16'hFFFF);
            r.humi_crc_ok   = (crc_acc == b);
            r.temp_crc_ok   = temp_crc_match;
            r.reading_valid = good;
            byte_pos        = 3'd0;
            if (good) begin
               raw  = temp_word;
               hraw = {humi_hi, humi_lo};
               tofs = $signed(cfg.temp_ofs);
               hofs = $signed(cfg.humi_ofs);
               // signed divide truncates toward zero
               r.temp_centi_c = 15'((raw * 17500 + (tofs - 4500) * 65535) / 65535);
               r.temp_centi_f = 16'((raw * 31500 + (tofs - 4900) * 65535) / 65535);
               r.humidity_pct = 8'((hraw * 200 + 65535) / 131070 + hofs);
            end
            return 1'b1;
         end
         default: begin
            crc_acc         = crc8_step(cfg.crc_init, b);
            temp_word[15:8] = b;
            byte_pos        = 3'd1;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic st,
                            input bit typed = 1'b0, input rsp_type typed_reading = '0);
      int      gap;
      rsp_type r;
      gap = tx_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push            <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= st;
      do @(posedge clock); while (full);
      bytes_sent++;
      if (decode_byte(b, st, r))
         pending_readings.push_back(typed ? typed_reading : r);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hFFFE;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // well-formed frame, cut short to nbytes where asked; CRC bytes sometimes corrupted
   task automatic send_frame(input int nbytes, input logic st);
      logic [7:0]  fb [6];
      logic [15:0] tw;
      logic [15:0] hw;
      tw    = pick_word();
      hw    = pick_word();
      fb[0] = tw[15:8];
      fb[1] = tw[7:0];
      fb[2] = crc8_step(crc8_step(cfg.crc_init, tw[15:8]), tw[7:0]);
      fb[3] = hw[15:8];
      fb[4] = hw[7:0];
      fb[5] = crc8_step(crc8_step(cfg.crc_init, hw[15:8]), hw[7:0]);
      if ($urandom_range(0, 7) == 0) fb[2] = 8'($urandom);
      if ($urandom_range(0, 7) == 0) fb[5] = 8'($urandom);
      for (int i = 0; i < nbytes; i++)
         send_byte(fb[i], (i == 0) ? st : 1'b0);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [10:0] data);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!ready);
      case (idx)
         CSR_CRC_POLY: cfg.crc_poly = data[7:0];
         CSR_CRC_INIT: cfg.crc_init = data[7:0];
         CSR_TEMP_OFS: cfg.temp_ofs = data;
         CSR_HUMI_OFS: cfg.humi_ofs = data[4:0];
      endcase
   endtask

   // drop push, wait out every outstanding reading plus the pipe depth
   task automatic wait_idle();
      push <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_phase_settings(input int phase);
      csr_type s;
      int      tv;
      int      hv;
      case (phase)
         0: s = '{8'h07, 8'h00, -11'sd1000, -5'sd10};
         1: s = '{8'hFF, 8'hFF, 11'sd1000, 5'sd10};
         2: s = '{8'h00, 8'hA5, 11'sd0, 5'sd0};
         3: begin
            tv = int'($urandom_range(0, 2000)) - 1000;
            hv = int'($urandom_range(0, 20)) - 10;
            s  = '{8'($urandom), 8'($urandom), tv[10:0], hv[4:0]};
         end
         default: s = '{CRC_POLY_RESET, CRC_INIT_RESET, TEMP_OFS_RESET, HUMI_OFS_RESET};
      endcase
      csr_write(CSR_CRC_POLY, 11'(s.crc_poly));
      csr_write(CSR_CRC_INIT, 11'(s.crc_init));
      csr_write(CSR_TEMP_OFS, s.temp_ofs);
      csr_write(CSR_HUMI_OFS, 11'(s.humi_ofs));
      valid <= 1'b0;
   endtask

   initial begin
      int kind;
      int phase_start;
      bit paused;
      reset           <= 1'b1;
      push            <= 1'b0;
      req_rx_byte     <= '0;
      req_frame_start <= 1'b0;
      valid           <= 1'b0;
      csr_index       <= CSR_CRC_POLY;
      csr_wdata       <= '0;
      cfg             = '{CRC_POLY_RESET, CRC_INIT_RESET, TEMP_OFS_RESET, HUMI_OFS_RESET};
      byte_pos        = 3'd0;
      crc_acc         = 8'hFF;
      temp_word       = 16'h0000;
      humi_hi         = 8'h00;
      humi_lo         = 8'h00;
      temp_crc_match  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx_byte, directed_rows[i].frame_start,
                   directed_rows[i].typed, directed_rows[i].reading);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         apply_phase_settings(p);
         phase_start = bytes_sent;
         paused      = 1'b0;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            kind     = $urandom_range(0, 99);
            if (kind < 80)
               send_frame(6, (byte_pos != 3'd0) ? 1'b1 : 1'($urandom_range(0, 1)));
            else if (kind < 90)
               send_frame($urandom_range(1, 5), 1'b1);
            else
               repeat ($urandom_range(1, 8))
                  send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            // hold the byte side once per phase until the result side runs dry
            if (!paused && bytes_sent - phase_start > PHASE_BYTES / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
         // finish any partial frame so settings only change between frames
         while (byte_pos != 3'd0)
            send_byte(8'($urandom), 1'b0);
      end

      wait_idle();
      if (pending_readings.size() != 0)
         note_error($sformatf("%0d readings never arrived", pending_readings.size()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rsp_type want;
      rsp_type got;
      int      stall;
      bit      rx_burst;
      rx_burst = 1'b0;
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got = {rsp_temp_centi_c, rsp_temp_centi_f, rsp_humidity_pct,
                rsp_temp_crc_ok, rsp_humi_crc_ok, rsp_reading_valid};
         if (pending_readings.size() == 0) begin
            note_error($sformatf("unexpected reading c=%0d f=%0d h=%0d flags=%b%b%b",
                       got.temp_centi_c, got.temp_centi_f, got.humidity_pct,
                       got.temp_crc_ok, got.humi_crc_ok, got.reading_valid));
         end else begin
            want = pending_readings.pop_front();
            if (got.temp_centi_c !== want.temp_centi_c ||
                got.temp_centi_f !== want.temp_centi_f ||
                got.humidity_pct !== want.humidity_pct ||
                got.temp_crc_ok !== want.temp_crc_ok ||
                got.humi_crc_ok !== want.humi_crc_ok ||
                got.reading_valid !== want.reading_valid)
               note_error($sformatf({"reading mismatch: exp c=%0d f=%0d h=%0d flags=%b%b%b,",
                          " got c=%0d f=%0d h=%0d flags=%b%b%b"},
                          want.temp_centi_c, want.temp_centi_f, want.humidity_pct,
                          want.temp_crc_ok, want.humi_crc_ok, want.reading_valid,
                          got.temp_centi_c, got.temp_centi_f, got.humidity_pct,
                          got.temp_crc_ok, got.humi_crc_ok, got.reading_valid));
         end
      end
   end

   // end the run if no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (valid && ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired after %0d idle cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
